>>> design/ptss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptss_pkg
// Shared types and codes of the priority thread slot scheduler.
// ----------------------------------------------------------------------------
package ptss_pkg;

  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_YIELD   = 3'd1,
    OP_EXIT    = 3'd2,
    OP_START   = 3'd3,
    OP_SET_PRI = 3'd4,
    OP_GET_PRI = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_FREE     = 2'd0,
    ST_RUNNABLE = 2'd1,
    ST_RUNNING  = 2'd2
  } slot_st_e;

  localparam logic [1:0] PRI_HIGH     = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NO_SLOT = 2'd1;
  localparam logic [1:0] STAT_STARTED = 2'd2;

  typedef struct packed {
    logic [2:0] operation;
    logic [1:0] priority_req;
  } in_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] slot;
    logic       switched;
    logic [1:0] old_priority;
    logic       all_done;
  } out_rsp_t;

  // One slot table entry as held in memory.
  typedef struct packed {
    slot_st_e   st;
    logic [1:0] pri;
  } slot_entry_t;

  // Summary gathered by one pass over the slot table.
  typedef struct packed {
    logic       free_found;
    logic       best_found;
    logic       any_live;
    slot_st_e   cur_st;
    logic [1:0] cur_pri;
    logic [1:0] best_pri;
  } scan_flags_t;

endpackage : ptss_pkg
`default_nettype wire

>>> design/ptss_slot_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptss_slot_mem
// Slot table: one write port, one read port, registered read data.
// Per-entry valid flops make never-written entries read as free, priority 0.
// ----------------------------------------------------------------------------
module ptss_slot_mem #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned AW    = 2
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 rd_en_i,
  input  wire logic [AW-1:0]        rd_addr_i,
  output ptss_pkg::slot_entry_t     rd_data_o,
  input  wire logic                 wr_en_i,
  input  wire logic [AW-1:0]        wr_addr_i,
  input  ptss_pkg::slot_entry_t     wr_data_i
);
  import ptss_pkg::*;

  slot_entry_t             mem_q [DEPTH];
  logic        [DEPTH-1:0] valid_q;
  slot_entry_t             rd_data_q;
  logic                    rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : slot_entry_t'('0);

endmodule : ptss_slot_mem
`default_nettype wire

>>> design/ptss_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptss_scan
// Walks the slot table one entry per enabled cycle: lowest free slot, best runnable
// slot (highest priority, ties to highest index), current slot's entry, and
// whether any slot stays live.
// ----------------------------------------------------------------------------
module ptss_scan #(
  parameter int unsigned IDX_W        = 2,
  parameter int unsigned CUR_W        = 3
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               clear_i,
  input  wire logic               en_i,
  input  wire logic [IDX_W-1:0]   idx_i,
  input  ptss_pkg::slot_entry_t   entry_i,
  input  wire logic [CUR_W-1:0]   cur_i,
  input  wire logic               exiting_i,
  output ptss_pkg::scan_flags_t   flags_o,
  output logic      [IDX_W-1:0]   free_idx_o,
  output logic      [IDX_W-1:0]   best_idx_o
);
  import ptss_pkg::*;

  scan_flags_t             flags_q;
  logic        [IDX_W-1:0] free_idx_q;
  logic        [IDX_W-1:0] best_idx_q;
  logic                    is_cur;
  slot_st_e                eff_st;

  assign is_cur = (CUR_W'(idx_i) == cur_i);

  // Exit frees the current slot; a running current slot competes as runnable.
  always_comb begin
    eff_st = entry_i.st;
    if (is_cur && exiting_i) begin
      eff_st = ST_FREE;
    end else if (is_cur && (entry_i.st == ST_RUNNING)) begin
      eff_st = ST_RUNNABLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q    <= '0;
      free_idx_q <= '0;
      best_idx_q <= '0;
    end else if (clear_i) begin
      flags_q    <= '0;
      free_idx_q <= '0;
      best_idx_q <= '0;
    end else if (en_i) begin
      if (is_cur) begin
        flags_q.cur_st  <= entry_i.st;
        flags_q.cur_pri <= entry_i.pri;
      end
      if ((entry_i.st == ST_FREE) && !flags_q.free_found) begin
        flags_q.free_found <= 1'b1;
        free_idx_q         <= idx_i;
      end
      if ((eff_st == ST_RUNNABLE) && (entry_i.pri >= flags_q.best_pri)) begin
        flags_q.best_found <= 1'b1;
        flags_q.best_pri   <= entry_i.pri;
        best_idx_q         <= idx_i;
      end
      if (eff_st != ST_FREE) begin
        flags_q.any_live <= 1'b1;
      end
    end
  end

  assign flags_o    = flags_q;
  assign free_idx_o = free_idx_q;
  assign best_idx_o = best_idx_q;

endmodule : ptss_scan
`default_nettype wire

>>> design/priority_thread_slot_scheduler_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// priority_thread_slot_scheduler_top
// Static-priority thread slot scheduler over a memory-held slot table.
// ----------------------------------------------------------------------------
// One transaction in, one result out. Create, yield, exit, start (first time)
// and set/get priority read the whole slot table through its single read
// port, one entry per cycle, then write back at most two entries in S_WR_CUR
// and S_WR_BEST, where the result is worked out, before S_OUT passes it to
// the result register; the next transaction is accepted back in S_IDLE. A
// repeated start or an unknown operation goes from S_IDLE straight to S_OUT.
// S_OUT waits while a stalled result still holds the output register. One
// transaction is in flight at a time; the result register holds a finished
// result while the next transaction is accepted.
module priority_thread_slot_scheduler_top #(
  parameter int unsigned THREAD_SLOTS = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  ptss_pkg::in_req_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output ptss_pkg::out_rsp_t out_data_o
);
  import ptss_pkg::*;

  localparam int unsigned IdxW = $clog2(THREAD_SLOTS);
  localparam int unsigned CurW = $clog2(THREAD_SLOTS + 1);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(THREAD_SLOTS - 1);
  localparam logic [CurW-1:0] CurNone  = CurW'(THREAD_SLOTS);
  localparam logic [2:0]      SlotNone = 3'(THREAD_SLOTS);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_WR_CUR  = 3'd2;
  localparam logic [2:0] S_WR_BEST = 3'd3;
  localparam logic [2:0] S_OUT     = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [2:0]      op_q;
  logic [1:0]      pri_q;
  logic            started_q;
  logic [CurW-1:0] cur_q;
  logic            rd_on_q;
  logic [IdxW-1:0] rd_idx_q;
  logic            pv_q;
  logic [IdxW-1:0] p_idx_q;
  out_rsp_t        res_q;
  logic            out_valid_q;
  out_rsp_t        out_data_q;

  logic            accept;
  logic            acc_scan;
  logic [1:0]      pri_sat;
  logic            cur_valid;
  logic [IdxW-1:0] cur_idx;
  logic            is_create, is_exit, is_pri_op, sched, best_sw;
  logic [CurW-1:0] best_ext, new_cur;
  logic            out_free;

  logic            rd_en;
  slot_entry_t     rd_data;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  slot_entry_t     wr_data;

  scan_flags_t     flags;
  logic [IdxW-1:0] free_idx, best_idx;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign pri_sat    = (in_data_i.priority_req > PRI_HIGH) ? PRI_HIGH : in_data_i.priority_req;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    unique case (in_data_i.operation) inside
      OP_START:                                   acc_scan = !started_q;
      OP_CREATE, OP_YIELD, OP_EXIT, OP_SET_PRI,
      OP_GET_PRI:                                 acc_scan = 1'b1;
      default:                                    acc_scan = 1'b0;
    endcase
  end

  assign cur_valid = (cur_q < CurNone);
  assign cur_idx   = cur_q[IdxW-1:0];
  assign is_create = (op_q == OP_CREATE);
  assign is_exit   = (op_q == OP_EXIT);
  assign is_pri_op = (op_q == OP_SET_PRI) || (op_q == OP_GET_PRI);
  assign sched     = (op_q == OP_YIELD) || (op_q == OP_START) || (is_exit && flags.any_live);
  assign best_sw   = sched && flags.best_found;
  assign best_ext  = CurW'(best_idx);

  always_comb begin
    new_cur = cur_q;
    if (best_sw) begin
      new_cur = best_ext;
    end else if (is_exit && !flags.any_live) begin
      new_cur = CurNone;
    end
  end

  // ---------------------------------------------------------------------------
  // Slot table and scan
  // ---------------------------------------------------------------------------
  assign rd_en = (state_q == S_SCAN) && rd_on_q;

  ptss_slot_mem #(
    .DEPTH (THREAD_SLOTS),
    .AW    (IdxW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_idx_q),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  ptss_scan #(
    .IDX_W        (IdxW),
    .CUR_W        (CurW)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (accept),
    .en_i       (pv_q),
    .idx_i      (p_idx_q),
    .entry_i    (rd_data),
    .cur_i      (cur_q),
    .exiting_i  (is_exit),
    .flags_o    (flags),
    .free_idx_o (free_idx),
    .best_idx_o (best_idx)
  );

  // Write-back: no reads are issued in the write states, so no forwarding.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_idx;
    wr_data = '{st: flags.cur_st, pri: flags.cur_pri};
    unique case (state_q)
      S_WR_CUR: begin
        unique case (op_q) inside
          OP_CREATE: begin
            wr_en   = flags.free_found;
            wr_addr = free_idx;
            wr_data = '{st: ST_RUNNABLE, pri: pri_q};
          end
          OP_EXIT: begin
            wr_en   = cur_valid;
            wr_data = '{st: ST_FREE, pri: flags.cur_pri};
          end
          OP_SET_PRI: begin
            wr_en   = cur_valid;
            wr_data = '{st: flags.cur_st, pri: pri_q};
          end
          OP_YIELD, OP_START: begin
            // running current slot steps back when another slot takes over
            wr_en   = cur_valid && (flags.cur_st == ST_RUNNING) && best_sw &&
                      (best_ext != cur_q);
            wr_data = '{st: ST_RUNNABLE, pri: flags.cur_pri};
          end
          default: begin
          end
        endcase
      end
      S_WR_BEST: begin
        wr_en   = best_sw;
        wr_addr = best_idx;
        wr_data = '{st: ST_RUNNING, pri: flags.best_pri};
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (accept) state_d = acc_scan ? S_SCAN : S_OUT;
      S_SCAN:    if (pv_q && (p_idx_q == LastIdx)) state_d = S_WR_CUR;
      S_WR_CUR:  state_d = S_WR_BEST;
      S_WR_BEST: state_d = S_OUT;
      S_OUT:     if (out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      started_q   <= 1'b0;
      cur_q       <= CurNone;
      rd_on_q     <= 1'b0;
      rd_idx_q    <= '0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pv_q    <= rd_en;
      if (accept) begin
        rd_on_q  <= acc_scan;
        rd_idx_q <= '0;
        if (in_data_i.operation == OP_START) begin
          started_q <= 1'b1;
        end
      end else if (rd_en) begin
        if (rd_idx_q == LastIdx) begin
          rd_on_q <= 1'b0;
        end else begin
          rd_idx_q <= rd_idx_q + 1'b1;
        end
      end
      if (state_q == S_WR_BEST) begin
        cur_q <= new_cur;
      end
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_idx_q <= rd_idx_q;
    if (accept) begin
      op_q  <= in_data_i.operation;
      pri_q <= pri_sat;
      // results of transactions that skip the scan
      res_q.status       <= ((in_data_i.operation == OP_START) && started_q) ?
                            STAT_STARTED : STAT_OK;
      res_q.slot         <= 3'(cur_q);
      res_q.switched     <= 1'b0;
      res_q.old_priority <= '0;
      res_q.all_done     <= 1'b0;
    end else if (state_q == S_WR_BEST) begin
      res_q.status       <= (is_create && !flags.free_found) ? STAT_NO_SLOT : STAT_OK;
      res_q.slot         <= is_create ? (flags.free_found ? 3'(free_idx) : SlotNone)
                                      : 3'(new_cur);
      res_q.switched     <= best_sw && (best_ext != cur_q);
      res_q.old_priority <= (is_pri_op && cur_valid) ? flags.cur_pri : 2'd0;
      res_q.all_done     <= is_exit && !flags.any_live;
    end
    if ((state_q == S_OUT) && out_free) begin
      out_data_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_wr_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !wr_en)
    else $error("slot table written during scan");

  a_cur_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= CurNone)
    else $error("current slot out of range");

  a_started_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |=> started_q)
    else $error("started flag cleared");

  a_wr_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR_CUR) |-> ($past(state_q) == S_SCAN) && !rd_on_q)
    else $error("write-back entered before scan finished");

  a_done_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.all_done) |->
      (out_data_o.slot == SlotNone) && !out_data_o.switched)
    else $error("all-done result names a slot");

endmodule : priority_thread_slot_scheduler_top
`default_nettype wire
